### rtl/mbq_pkg.sv
// Shared types and constants for the multichannel biquad filter.
// No dependencies; imported by the top level and the testbench.
package mbq_pkg;

    // Field widths
    localparam int CHAN_W    = 3;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Arithmetic widths: one product, then five products summed
    localparam int PROD_W = COEF_W + SAMPLE_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam int QUO_W  = ACC_W - FRAC_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_B0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_B1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_B2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_A1 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_A2 = CFG_IDX_W'(4);

    // Coefficient reset values (Q2.16): unity pass-through
    localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(2 ** FRAC_W);
    localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

    // Input transaction
    typedef struct packed {
        logic [CHAN_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] sample_in;
    } t_in;

    // Output transaction
    typedef struct packed {
        logic [CHAN_W-1:0]          channel_out;
        logic signed [SAMPLE_W-1:0] sample_out;
    } t_out;

    // Per-channel history entry
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x1;
        logic signed [SAMPLE_W-1:0] x2;
        logic signed [SAMPLE_W-1:0] y1;
        logic signed [SAMPLE_W-1:0] y2;
    } t_hist;

endpackage

### rtl/multichannel_biquad_filter.sv
// Top level of the multichannel biquad filter: pipeline, coefficients, history RAM.
// Depends on mbq_pkg and mbq_ram.
//
// Direct form I biquad shared by up to CHANNELS channels. Each input transaction carries a
// channel and a sample; one output transaction returns the filtered, rounded and saturated
// sample for that channel. The x1/x2/y1/y2 history of each channel lives in one RAM entry
// and is read, used and written back in a three-stage pipeline: RAM read at accept, five
// coefficient products, then sum/round/saturate into the output register together with
// the history write. Transactions on different channels are accepted one per cycle while
// the output is not stalled; a second transaction on the same channel is held while the
// first is in stage 1, because of the history read-modify-write loop through the RAM, and
// picks up the first one's write through a bypass register.
// History reads as zero after reset through per-entry valid bits; there is no clearing
// pass. Channels at or above CHANNELS use an all-zero history and leave it unchanged.
// Coefficients must be written only while the block is idle; the block does not enforce it.
module multichannel_biquad_filter
    import mbq_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(2 ** (FRAC_W - 1));
    localparam logic signed [QUO_W-1:0] Q_MAX    = QUO_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [QUO_W-1:0] Q_MIN    = ~Q_MAX;

    // Coefficients
    logic signed [COEF_W-1:0] r_coef_b0, r_coef_b1, r_coef_b2, r_coef_a1, r_coef_a2;

    // Stage 1: history read returned
    logic                       r_s1_valid;
    logic [CHAN_W-1:0]          r_s1_chan;
    logic [AW-1:0]              r_s1_addr;
    logic                       r_s1_inr;
    logic signed [SAMPLE_W-1:0] r_s1_x;

    // Stage 2: products registered
    logic                       r_s2_valid;
    logic [CHAN_W-1:0]          r_s2_chan;
    logic [AW-1:0]              r_s2_addr;
    logic                       r_s2_inr;
    logic signed [SAMPLE_W-1:0] r_s2_x;
    t_hist                      r_s2_hist;
    logic signed [PROD_W-1:0]   r_p_b0, r_p_b1, r_p_b2, r_p_a1, r_p_a2;

    // Output register
    logic r_out_valid;
    t_out r_out;

    // Last history write, for same-channel forwarding
    logic          r_byp_valid;
    logic [AW-1:0] r_byp_addr;
    t_hist         r_byp_data;

    // Entries written since reset
    logic [CHANNELS-1:0] r_entry_valid;

    logic                       advance;
    logic                       in_inr;
    logic                       hazard;
    logic                       in_fire;
    logic [AW-1:0]              in_addr;
    logic [$bits(t_hist)-1:0]   ram_rdata;
    logic                       ram_we;
    t_hist                      s1_hist;
    t_hist                      s2_new;
    logic signed [PROD_W-1:0]   n_p_b0, n_p_b1, n_p_b2, n_p_a1, n_p_a2;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [QUO_W-1:0]    quo;
    logic signed [SAMPLE_W-1:0] y_sat;

    // Handshake: stall everything while the output register is full and not taken
    assign advance    = !r_out_valid || i_out_ready;
    assign in_inr     = (32'(i_in.channel) < CHANNELS);
    assign in_addr    = AW'(i_in.channel);
    // Hold a same-channel transaction until the one ahead reaches the write stage
    assign hazard     = r_s1_valid && r_s1_inr && in_inr && (i_in.channel == r_s1_chan);
    assign o_in_ready = advance && !hazard;
    assign in_fire    = i_in_valid && o_in_ready;
    assign ram_we     = r_s2_valid && r_s2_inr && advance;

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_b0 <= COEF_ONE;
            r_coef_b1 <= COEF_ZERO;
            r_coef_b2 <= COEF_ZERO;
            r_coef_a1 <= COEF_ZERO;
            r_coef_a2 <= COEF_ZERO;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_B0:  r_coef_b0 <= i_cfg_data;
                CFG_B1:  r_coef_b1 <= i_cfg_data;
                CFG_B2:  r_coef_b2 <= i_cfg_data;
                CFG_A1:  r_coef_a1 <= i_cfg_data;
                CFG_A2:  r_coef_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // History RAM
    mbq_ram #(
        .WIDTH ($bits(t_hist)),
        .DEPTH (CHANNELS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s2_addr),
        .i_wdata (s2_new),
        .i_re    (in_fire),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // Select stage 1 history: bypass, then RAM, zero when never written or out of range
    always_comb begin
        if (!r_s1_inr) begin
            s1_hist = '0;
        end else if (r_byp_valid && (r_byp_addr == r_s1_addr)) begin
            s1_hist = r_byp_data;
        end else if (r_entry_valid[r_s1_addr]) begin
            s1_hist = t_hist'(ram_rdata);
        end else begin
            s1_hist = '0;
        end
    end

    // Stage 1 products
    always_comb begin
        n_p_b0 = r_coef_b0 * r_s1_x;
        n_p_b1 = r_coef_b1 * s1_hist.x1;
        n_p_b2 = r_coef_b2 * s1_hist.x2;
        n_p_a1 = r_coef_a1 * s1_hist.y1;
        n_p_a2 = r_coef_a2 * s1_hist.y2;
    end

    // Stage 2: sum, round to nearest, saturate, build the new history entry
    always_comb begin
        acc     = r_p_b0 + r_p_b1 + r_p_b2 - r_p_a1 - r_p_a2;
        acc_rnd = acc + ACC_HALF;
        quo     = acc_rnd[ACC_W-1:FRAC_W];
        if (quo > Q_MAX) begin
            y_sat = SAMPLE_W'(Q_MAX);
        end else if (quo < Q_MIN) begin
            y_sat = SAMPLE_W'(Q_MIN);
        end else begin
            y_sat = SAMPLE_W'(quo);
        end
        s2_new.x1 = r_s2_x;
        s2_new.x2 = r_s2_hist.x1;
        s2_new.y1 = y_sat;
        s2_new.y2 = r_s2_hist.y1;
    end

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_byp_valid   <= 1'b0;
            r_entry_valid <= '0;
        end else begin
            if (advance) begin
                r_s1_valid  <= in_fire;
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= r_s2_valid;
            end
            if (ram_we) begin
                r_byp_valid              <= 1'b1;
                r_entry_valid[r_s2_addr] <= 1'b1;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_chan <= i_in.channel;
            r_s1_addr <= in_addr;
            r_s1_inr  <= in_inr;
            r_s1_x    <= i_in.sample_in;
        end
        if (advance) begin
            r_s2_chan <= r_s1_chan;
            r_s2_addr <= r_s1_addr;
            r_s2_inr  <= r_s1_inr;
            r_s2_x    <= r_s1_x;
            r_s2_hist <= s1_hist;
            r_p_b0    <= n_p_b0;
            r_p_b1    <= n_p_b1;
            r_p_b2    <= n_p_b2;
            r_p_a1    <= n_p_a1;
            r_p_a2    <= n_p_a2;
            r_out.channel_out <= r_s2_chan;
            r_out.sample_out  <= y_sat;
        end
        if (ram_we) begin
            r_byp_addr <= r_s2_addr;
            r_byp_data <= s2_new;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // Never accept a transaction whose channel is still in stage 1
    a_no_hazard_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_s1_valid && r_s1_inr && in_inr) |-> (i_in.channel != r_s1_chan))
        else $error("same-channel transaction accepted behind stage 1");

    // History writes only come from an in-range stage 2 transaction
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_s2_valid && (32'(r_s2_chan) < CHANNELS)))
        else $error("history write without a valid in-range transaction");

    // Output valid only rises after a transaction sat in stage 2
    a_out_from_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s2_valid))
        else $error("output valid without a stage 2 transaction");

    // Pipeline holds while the output is stalled
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(r_s2_valid) && $stable(r_s1_valid)))
        else $error("pipeline moved during an output stall");
`endif

endmodule

### rtl/mbq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mbq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### test/tb_multichannel_biquad_filter.sv
// Self-checking testbench for the multichannel biquad filter top level.
// Depends on mbq_pkg (types, widths, register indexes) and the filter RTL.
module tb_multichannel_biquad_filter
    import mbq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CHANNELS   = 8;
    localparam int PIPE_LATENCY   = 3;
    localparam int STALL_LIMIT    = 5000;
    localparam int RANDOM_SETS    = 6;
    localparam int ITEMS_PER_SET  = 225;
    localparam int PAUSE_INTERVAL = 60;
    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam longint ROUND_HALF = longint'(1) <<< (FRAC_W - 1);
    localparam logic signed [COEF_W-1:0] COEF_MAX  = {1'b0, {(COEF_W - 1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN  = {1'b1, {(COEF_W - 1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_HALF = COEF_W'(2 ** (FRAC_W - 1));
    localparam logic signed [SAMPLE_W-1:0] S_MAX   = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] S_MIN   = {1'b1, {(SAMPLE_W - 1){1'b0}}};

    // DUT connections
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in                  i_in;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out                 o_out;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COEF_W-1:0]    i_cfg_data;

    // Filter model state: shared coefficients and per-channel history
    logic signed [COEF_W-1:0] coef_model [int'(CFG_A2) + 1];
    t_hist                    history_model [NUM_CHANNELS];
    t_out                     expected_samples [$];

    int   send_idle_pct;
    int   recv_stall_pct;
    int   error_count;
    int   quiet_cycles;
    t_out seen_out;
    t_out want_out;

    multichannel_biquad_filter #(
        .CHANNELS(NUM_CHANNELS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Filter one sample on the model and advance that channel's history
    function automatic t_out biquad_predict(t_in item);
        t_hist  h;
        longint acc;
        longint y;
        t_out   res;
        h = (int'(item.channel) < NUM_CHANNELS) ? history_model[item.channel] : '0;
        acc = longint'(coef_model[CFG_B0]) * longint'(item.sample_in)
            + longint'(coef_model[CFG_B1]) * longint'(h.x1)
            + longint'(coef_model[CFG_B2]) * longint'(h.x2)
            - longint'(coef_model[CFG_A1]) * longint'(h.y1)
            - longint'(coef_model[CFG_A2]) * longint'(h.y2);
        y = (acc + ROUND_HALF) >>> FRAC_W;
        if (y > SAMPLE_MAX) y = SAMPLE_MAX;
        if (y < SAMPLE_MIN) y = SAMPLE_MIN;
        res.channel_out = item.channel;
        res.sample_out  = SAMPLE_W'(y);
        if (int'(item.channel) < NUM_CHANNELS) begin
            history_model[item.channel].x2 = h.x1;
            history_model[item.channel].x1 = item.sample_in;
            history_model[item.channel].y2 = h.y1;
            history_model[item.channel].y1 = res.sample_out;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    // Offer one input transaction; hold it until accepted, then record its expectation
    task automatic send_sample(input logic [CHAN_W-1:0] chan, input logic [SAMPLE_W-1:0] smp);
        t_in item;
        item.channel   = chan;
        item.sample_in = smp;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in       = item;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        expected_samples.push_back(biquad_predict(item));
    endtask

    // Drop valid and wait for every outstanding result, leaving time at a falling edge
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(negedge i_clk);
    endtask

    // Register write; caller is at a falling edge with the block idle
    task automatic write_coef(input int idx, input logic [COEF_W-1:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = CFG_IDX_W'(idx);
        i_cfg_data  = value;
        if (idx <= int'(CFG_A2)) coef_model[idx] = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                                   input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                                   input logic [COEF_W-1:0] a2);
        wait_drained();
        write_coef(CFG_B0, b0);
        write_coef(CFG_B1, b1);
        write_coef(CFG_B2, b2);
        write_coef(CFG_A1, a1);
        write_coef(CFG_A2, a2);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9))
            0:       return S_MIN;
            1:       return S_MAX;
            2, 3, 4: return SAMPLE_W'($urandom_range(511) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Reset coefficients give a unity pass-through on a cleared history
    task automatic test_unity_passthrough();
        send_sample(0, S_MIN);
        send_sample(7, S_MAX);
        send_sample(3, '0);
        send_sample(5, '1);
        send_sample(1, SAMPLE_W'(1));
        send_sample(2, 16'h5555);
        send_sample(6, 16'hAAAA);
        send_sample(4, 16'h0F0F);
    endtask

    // Largest and smallest coefficients drive the output into both rails
    task automatic test_saturation();
        write_all_coefs(COEF_MAX, '0, '0, '0, '0);
        send_sample(0, S_MAX);
        send_sample(1, S_MIN);
        send_sample(2, SAMPLE_W'(16384));
        write_all_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        repeat (4) send_sample(3, S_MAX);
        repeat (3) send_sample(4, S_MIN);
        write_all_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        send_sample(5, S_MAX);
        send_sample(5, S_MIN);
    endtask

    // Half-unity gain lands exactly on ties: positive ties go up, negative ties go up too
    task automatic test_rounding_ties();
        write_all_coefs(COEF_HALF, '0, '0, '0, '0);
        send_sample(6, SAMPLE_W'(1));
        send_sample(7, '1);
        send_sample(0, SAMPLE_W'(3));
        send_sample(1, SAMPLE_W'(-3));
    endtask

    // Writes beyond the register list must leave the coefficients alone
    task automatic test_unused_indexes();
        write_all_coefs(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
        for (int k = int'(CFG_A2) + 1; k < 2 ** CFG_IDX_W; k++)
            write_coef(k, COEF_W'($urandom));
        send_sample(2, SAMPLE_W'(1234));
        send_sample(3, SAMPLE_W'(-4321));
    endtask

    // Random coefficient sets, channel streams with repeats, all idling phases
    task automatic test_random_filters();
        logic [CHAN_W-1:0] chan;
        logic [COEF_W-1:0] c [5];
        chan = '0;
        for (int s = 0; s < RANDOM_SETS; s++) begin
            wait_drained();
            for (int k = 0; k <= int'(CFG_A2); k++)
                c[k] = (s % 2 == 0) ? COEF_W'($urandom_range(65535) - 32768)
                                    : COEF_W'($urandom);
            write_all_coefs(c[0], c[1], c[2], c[3], c[4]);
            if ($urandom_range(1))
                write_coef($urandom_range(2 ** CFG_IDX_W - 1, int'(CFG_A2) + 1),
                           COEF_W'($urandom));
            case (s % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                // hold back until the pipeline is empty now and then
                if (n % PAUSE_INTERVAL == PAUSE_INTERVAL - 1) wait_drained();
                if ($urandom_range(1)) chan = CHAN_W'($urandom);
                send_sample(chan, random_sample());
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Output stall pattern, changed at the falling edge
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each output transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_out = o_out;
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected output ch %0d sample %0d",
                                          seen_out.channel_out, seen_out.sample_out));
            end else begin
                want_out = expected_samples.pop_front();
                if (seen_out.channel_out !== want_out.channel_out)
                    report_mismatch($sformatf("channel_out %0d, want %0d",
                                              seen_out.channel_out, want_out.channel_out));
                if (seen_out.sample_out !== want_out.sample_out)
                    report_mismatch($sformatf("ch %0d sample_out %0d, want %0d",
                                              want_out.channel_out, seen_out.sample_out,
                                              want_out.sample_out));
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        coef_model[CFG_B0] = COEF_ONE;
        for (int k = int'(CFG_B1); k <= int'(CFG_A2); k++) coef_model[k] = COEF_ZERO;
        for (int k = 0; k < NUM_CHANNELS; k++) history_model[k] = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_unity_passthrough();
        test_saturation();
        test_rounding_ties();
        test_unused_indexes();
        test_random_filters();

        wait_drained();
        repeat (PIPE_LATENCY * 3) @(posedge i_clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
rtl/mbq_pkg.sv
rtl/mbq_ram.sv
rtl/multichannel_biquad_filter.sv
test/tb_multichannel_biquad_filter.sv
